@@ rtl/stat_line_field_extractor_defines.svh @@
// Assertion macros for the stat line field extractor.
// Used by stat_line_field_extractor.sv; expects clk and rst_n in scope.
`ifndef STAT_LINE_FIELD_EXTRACTOR_DEFINES_SVH
`define STAT_LINE_FIELD_EXTRACTOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SLFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SLFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/slfe_pkg.sv @@
// Package for the stat line field extractor: scan state type, character
// codes, field numbers and the per-byte scan functions. No dependencies.
`timescale 1ns / 1ps

package slfe_pkg;

  localparam logic [7:0] CH_PAREN = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] FIRST_FIELD  = 5'd3;
  localparam logic [4:0] USER_FIELD   = 5'd14;
  localparam logic [4:0] SYSTEM_FIELD = 5'd15;
  localparam logic [4:0] START_FIELD  = 5'd22;
  localparam logic [4:0] FIELD_MAX    = 5'd31;

  localparam logic [63:0] ACCUM_LIMIT     = 64'd1844674407370955161;
  localparam logic [3:0]  LAST_DIGIT_OK   = 4'd5;

  typedef struct packed {
    logic        paren_seen;
    logic        scan_stopped;
    logic [4:0]  field_number;
    logic        inside_token;
    logic [63:0] number_accum;
    logic        token_bad;
    logic [63:0] user_ticks;
    logic        user_ok;
    logic [63:0] system_ticks;
    logic        system_ok;
    logic [63:0] start_value;
    logic        start_found;
  } scan_state_t;

  typedef struct packed {
    logic        user_ok;
    logic [63:0] user_ticks;
    logic        system_ok;
    logic [63:0] system_ticks;
    logic        start_found;
    logic [63:0] start_value;
  } line_fields_t;

  function automatic scan_state_t close_token(scan_state_t s);
    scan_state_t r;
    r = s;
    if (s.inside_token) begin
      if (!s.token_bad) begin
        case (s.field_number)
          USER_FIELD: begin
            r.user_ticks = s.number_accum;
            r.user_ok    = 1'b1;
          end
          SYSTEM_FIELD: begin
            r.system_ticks = s.number_accum;
            r.system_ok    = 1'b1;
          end
          START_FIELD: begin
            r.start_value = s.number_accum;
            r.start_found = 1'b1;
          end
          default: ;
        endcase
      end
      if (s.field_number < FIELD_MAX) begin
        r.field_number = s.field_number + 5'd1;
      end
      r.inside_token = 1'b0;
    end
    return r;
  endfunction

  function automatic scan_state_t take_char(scan_state_t s, logic [7:0] c);
    scan_state_t r;
    logic [63:0] acc;
    logic [3:0]  d;
    r = s;
    if (!s.inside_token) begin
      r.inside_token = 1'b1;
      r.number_accum = '0;
      r.token_bad    = 1'b0;
    end
    acc = r.number_accum;
    d   = c[3:0];
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (acc > ACCUM_LIMIT || (acc == ACCUM_LIMIT && d > LAST_DIGIT_OK)) begin
        r.number_accum = '1;
      end else begin
        r.number_accum = (acc << 3) + (acc << 1) + {60'd0, d};
      end
    end else begin
      r.token_bad = 1'b1;
    end
    return r;
  endfunction

  function automatic scan_state_t scan_byte(scan_state_t s, logic [7:0] c);
    scan_state_t r;
    r = s;
    if (!s.scan_stopped) begin
      case (c)
        CH_PAREN: begin
          r              = '0;
          r.paren_seen   = 1'b1;
          r.field_number = FIRST_FIELD;
        end
        CH_NUL, CH_NL: begin
          r              = close_token(s);
          r.scan_stopped = 1'b1;
        end
        CH_SPACE: begin
          r = close_token(s);
        end
        default: begin
          if (s.paren_seen) begin
            r = take_char(s, c);
          end
        end
      endcase
    end
    return r;
  endfunction

endpackage

@@ rtl/slfe_if.sv @@
// Valid/ready channel interfaces for the stat line field extractor.
// Depends on nothing but the payload widths of the block.
`timescale 1ns / 1ps

interface slfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_line;

  modport source (output valid, output text_byte, output end_of_line, input ready);
  modport sink   (input valid, input text_byte, input end_of_line, output ready);
endinterface

interface slfe_out_if;
  logic        valid;
  logic        ready;
  logic        cpu_ok;
  logic [63:0] cpu_ticks;
  logic        start_ok;
  logic [63:0] start_ticks;

  modport source (output valid, output cpu_ok, output cpu_ticks, output start_ok,
                  output start_ticks, input ready);
  modport sink   (input valid, input cpu_ok, input cpu_ticks, input start_ok,
                  input start_ticks, output ready);
endinterface

@@ rtl/stat_line_field_extractor.sv @@
// Channel   Dir  Payload                                       Beat
// in_ch     in   text_byte[7:0], end_of_line                   one char per beat
// out_ch    out  cpu_ok, cpu_ticks[63:0], start_ok, start_ticks one result per line
//
// One byte per cycle while in_ch.ready is high; the scan state updates in the cycle the beat is taken.
// A result passes from its end_of_line beat into the field capture
// stage, then through the 64-bit user+system add into the output register.
// Reset (rst_n low, synchronous) clears the scan state and the valid flags of both stages.
// A stalled out_ch fills both stages, then in_ch.ready drops for every byte;
// until both stages hold a result, any byte is taken.
// Depends on slfe_pkg, slfe_if and stat_line_field_extractor_defines.svh.
`timescale 1ns / 1ps
`include "stat_line_field_extractor_defines.svh"

module stat_line_field_extractor (
  input  logic              clk,
  input  logic              rst_n,
  slfe_in_if.sink           in_ch,
  slfe_out_if.source        out_ch
);

  slfe_pkg::scan_state_t  state_r, state_nxt, byte_s, final_s;
  slfe_pkg::line_fields_t fields_r, fields_nxt;
  logic                   fields_valid_r;
  logic                   fields_adv;
  logic                   in_acc;
  logic                   out_valid_r;
  logic                   cpu_ok_r, start_ok_r;
  logic [63:0]            cpu_ticks_r, start_ticks_r;

  assign fields_adv  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !fields_valid_r || fields_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    byte_s  = slfe_pkg::scan_byte(state_r, in_ch.text_byte);
    final_s = byte_s.scan_stopped ? byte_s : slfe_pkg::close_token(byte_s);
    state_nxt = in_ch.end_of_line ? '0 : byte_s;
    fields_nxt.user_ok      = final_s.user_ok;
    fields_nxt.user_ticks   = final_s.user_ticks;
    fields_nxt.system_ok    = final_s.system_ok;
    fields_nxt.system_ticks = final_s.system_ticks;
    fields_nxt.start_found  = final_s.start_found;
    fields_nxt.start_value  = final_s.start_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fields_valid_r <= 1'b0;
    end else if (in_acc && in_ch.end_of_line) begin
      fields_valid_r <= 1'b1;
    end else if (fields_adv) begin
      fields_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.end_of_line) begin
      fields_r <= fields_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fields_adv) begin
      out_valid_r <= fields_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fields_adv && fields_valid_r) begin
      cpu_ok_r      <= fields_r.user_ok && fields_r.system_ok;
      cpu_ticks_r   <= (fields_r.user_ok && fields_r.system_ok) ?
                       fields_r.user_ticks + fields_r.system_ticks : 64'd0;
      start_ok_r    <= fields_r.start_found;
      start_ticks_r <= fields_r.start_found ? fields_r.start_value : 64'd0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cpu_ok      = cpu_ok_r;
  assign out_ch.cpu_ticks   = cpu_ticks_r;
  assign out_ch.start_ok    = start_ok_r;
  assign out_ch.start_ticks = start_ticks_r;

  `SLFE_ASSERT_NEXT(a_line_end_clears, in_acc && in_ch.end_of_line, state_r == '0 && fields_valid_r, "scan state not cleared after line end")
  `SLFE_ASSERT_NEXT(a_fields_to_out, fields_valid_r && fields_adv, out_ch.valid, "captured fields did not reach the output")
  `SLFE_ASSERT_NOW(a_ready_backpressure, !in_ch.ready, fields_valid_r && out_valid_r && !out_ch.ready, "input stalled with room downstream")
  `SLFE_ASSERT_NOW(a_cpu_zero, out_ch.valid && !out_ch.cpu_ok, out_ch.cpu_ticks == 64'd0, "cpu ticks nonzero without cpu_ok")

endmodule

@@ tb/stat_line_field_extractor_tb.sv @@
// Testbench for stat_line_field_extractor: streams stat lines byte by byte and checks
// the cpu and start tick totals of each line against a scoreboard's own line scanner.
// Depends on slfe_pkg, slfe_if and the block's RTL.
`timescale 1ns / 1ps

module stat_line_field_extractor_tb;

  localparam int ITEM_TARGET  = 1550;
  localparam int MIN_LINES    = 40;
  localparam int PRESSURE_AT  = 20;
  localparam int HOLD_CYCLES  = 120;
  localparam int STUCK_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {TERM_EOL_ONLY, TERM_NEWLINE, TERM_NEWLINE_JUNK, TERM_NUL_JUNK} line_end_t;

  class line_tick_checker;
    typedef struct {
      bit        cpu_ok;
      bit [63:0] cpu_ticks;
      bit        start_ok;
      bit [63:0] start_ticks;
    } line_totals_t;

    line_totals_t pending_totals[$];
    bit        after_paren, halted, in_token, token_bad;
    bit        user_ok, system_ok, start_found;
    bit [4:0]  field_idx;
    bit [63:0] accum, user_ticks, system_ticks, start_value;
    int        errors, checked, cpu_seen, start_seen;

    function new();
      clear_fields();
      after_paren = 1'b0;
      halted = 1'b0;
      field_idx = '0;
    endfunction

    function void clear_fields();
      in_token = 1'b0;
      accum = '0;
      token_bad = 1'b0;
      user_ticks = '0;
      user_ok = 1'b0;
      system_ticks = '0;
      system_ok = 1'b0;
      start_value = '0;
      start_found = 1'b0;
    endfunction

    function void end_token();
      if (!in_token) return;
      if (!token_bad) begin
        if (field_idx == slfe_pkg::USER_FIELD) begin
          user_ticks = accum;
          user_ok = 1'b1;
        end else if (field_idx == slfe_pkg::SYSTEM_FIELD) begin
          system_ticks = accum;
          system_ok = 1'b1;
        end else if (field_idx == slfe_pkg::START_FIELD) begin
          start_value = accum;
          start_found = 1'b1;
        end
      end
      if (field_idx < slfe_pkg::FIELD_MAX) field_idx++;
      in_token = 1'b0;
    endfunction

    function void add_char(logic [7:0] c);
      bit [3:0] d;
      if (!in_token) begin
        in_token = 1'b1;
        accum = '0;
        token_bad = 1'b0;
      end
      if (c >= slfe_pkg::CH_ZERO && c <= slfe_pkg::CH_NINE) begin
        d = 4'(c - slfe_pkg::CH_ZERO);
        if (accum > slfe_pkg::ACCUM_LIMIT ||
            (accum == slfe_pkg::ACCUM_LIMIT && d > slfe_pkg::LAST_DIGIT_OK))
          accum = '1;
        else
          accum = accum * 64'd10 + 64'(d);
      end else begin
        token_bad = 1'b1;
      end
    endfunction

    function void take_byte(logic [7:0] c, logic eol);
      line_totals_t t;
      if (!halted) begin
        if (c == slfe_pkg::CH_PAREN) begin
          after_paren = 1'b1;
          field_idx = slfe_pkg::FIRST_FIELD;
          clear_fields();
        end else if (c == slfe_pkg::CH_NUL || c == slfe_pkg::CH_NL) begin
          end_token();
          halted = 1'b1;
        end else if (c == slfe_pkg::CH_SPACE) begin
          end_token();
        end else if (after_paren) begin
          add_char(c);
        end
      end
      if (!eol) return;
      if (!halted) end_token();
      t.cpu_ok = user_ok && system_ok;
      t.cpu_ticks = t.cpu_ok ? user_ticks + system_ticks : 64'd0;
      t.start_ok = start_found;
      t.start_ticks = start_found ? start_value : 64'd0;
      pending_totals.push_back(t);
      after_paren = 1'b0;
      halted = 1'b0;
      field_idx = '0;
      clear_fields();
    endfunction

    function void check_totals(logic cpu_ok, logic [63:0] cpu_ticks,
                               logic start_ok, logic [63:0] start_ticks);
      line_totals_t t;
      if (pending_totals.size() == 0) begin
        $error("unexpected result beat: cpu_ok=%0b cpu_ticks=%0d start_ok=%0b start_ticks=%0d",
               cpu_ok, cpu_ticks, start_ok, start_ticks);
        errors++;
        return;
      end
      t = pending_totals.pop_front();
      checked++;
      if (t.cpu_ok) cpu_seen++;
      if (t.start_ok) start_seen++;
      if (cpu_ok !== t.cpu_ok) begin
        $error("cpu_ok expected %0b got %0b", t.cpu_ok, cpu_ok);
        errors++;
      end
      if (cpu_ticks !== t.cpu_ticks) begin
        $error("cpu_ticks expected %0d got %0d", t.cpu_ticks, cpu_ticks);
        errors++;
      end
      if (start_ok !== t.start_ok) begin
        $error("start_ok expected %0b got %0b", t.start_ok, start_ok);
        errors++;
      end
      if (start_ticks !== t.start_ticks) begin
        $error("start_ticks expected %0d got %0d", t.start_ticks, start_ticks);
        errors++;
      end
    endfunction

    function int pending();
      return pending_totals.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  slfe_in_if  in_ch();
  slfe_out_if out_ch();

  stat_line_field_extractor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  line_tick_checker board = new();
  logic [7:0] line_q[$];
  bit src_quiet, sink_quiet, hold_req;
  int bytes_sent, lines_sent, holds_done, idle_cycles;

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic string key_field_text();
    int r;
    bit [63:0] v;
    string s;
    r = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (r < 35) s = $sformatf("%0d", $urandom_range(0, 999));
    else if (r < 50) s = $sformatf("%0d", v);
    else if (r < 56) s = "18446744073709551615";
    else if (r < 62) s = $sformatf("1844674407370955161%0d", $urandom_range(0, 9));
    else if (r < 66) s = "184467440737095516150";
    else if (r < 70) s = $sformatf("000%0d", v[15:0]);
    else if (r < 74) s = $sformatf("-%0d", v[7:0]);
    else if (r < 77) s = $sformatf("+%0d", v[7:0]);
    else if (r < 81) s = $sformatf("%0dx", v[7:0]);
    else if (r < 84) s = $sformatf("\t%0d", v[7:0]);
    else if (r < 87) s = "a";
    else s = $sformatf("%0d", v[31:0]);
    return s;
  endfunction

  function automatic string filler_text();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $sformatf("%0d", $urandom_range(0, 9));
    if (r < 92) return $sformatf("%0d", $urandom_range(10, 99999));
    return "S";
  endfunction

  function automatic string comm_text();
    int r;
    string s;
    r = $urandom_range(0, 99);
    s = "";
    if (r < 60) s = "sh";
    else if (r < 75) s = "a b";
    else if (r < 85) s = "x) y";
    else if (r < 95) begin
      repeat ($urandom_range(1, 4)) s = {s, $sformatf("%c", 8'($urandom_range(33, 126)))};
    end
    return s;
  endfunction

  function automatic int pick_last_field();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(22, 24);
    if (r < 85) return $urandom_range(3, 21);
    return $urandom_range(25, 40);
  endfunction

  function automatic void build_line(string comm, string f_user, string f_system,
                                     string f_start, int last_field, line_end_t term);
    push_text({"1 (", comm, ") S"});
    for (int f = 4; f <= last_field; f++) begin
      if (f == slfe_pkg::USER_FIELD) push_text({" ", f_user});
      else if (f == slfe_pkg::SYSTEM_FIELD) push_text({" ", f_system});
      else if (f == slfe_pkg::START_FIELD) push_text({" ", f_start});
      else push_text({" ", filler_text()});
    end
    case (term)
      TERM_NEWLINE: begin
        line_q.push_back(slfe_pkg::CH_NL);
      end
      TERM_NEWLINE_JUNK: begin
        line_q.push_back(slfe_pkg::CH_NL);
        push_text(") 3 4");
      end
      TERM_NUL_JUNK: begin
        line_q.push_back(slfe_pkg::CH_NUL);
        push_text(" ) 12");
      end
      default: ;
    endcase
  endfunction

  function automatic void build_noise();
    int r;
    repeat ($urandom_range(1, 24)) begin
      r = $urandom_range(0, 99);
      if (r < 15) line_q.push_back(slfe_pkg::CH_PAREN);
      else if (r < 30) line_q.push_back(slfe_pkg::CH_SPACE);
      else if (r < 45) line_q.push_back(8'(slfe_pkg::CH_ZERO + $urandom_range(0, 9)));
      else line_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic eol);
    int gap;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= c;
    in_ch.end_of_line <= eol;
    do @(posedge clk); while (!in_ch.ready);
    board.take_byte(c, eol);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_beat(line_q[i], i == line_q.size() - 1);
    line_q.delete();
    lines_sent++;
  endtask

  // hold the result side off while short lines keep coming
  task automatic run_backpressure();
    src_quiet = 1'b1;
    hold_req = 1'b1;
    repeat (14) begin
      push_text($sformatf(") %0d", $urandom_range(0, 9)));
      send_line();
    end
    src_quiet = 1'b0;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        int stall;
        stall = pick_gap(sink_quiet);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_totals(out_ch.cpu_ok, out_ch.cpu_ticks, out_ch.start_ok, out_ch.start_ticks);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("stat_line_field_extractor verification failed");
      $finish;
    end
  end

  initial begin
    bit quiet;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.text_byte <= '0;
    in_ch.end_of_line <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    line_q.push_back(slfe_pkg::CH_NL);
    send_line();
    push_text("12 34 56");
    send_line();
    build_line("sh", "18446744073709551615", "2", "18446744073709551615", 22, TERM_NEWLINE);
    send_line();
    build_line("x", "18446744073709551616", "99999999999999999999999", "0", 23, TERM_NEWLINE);
    send_line();
    build_line("a", "-5", "+7", "1x", 22, TERM_NEWLINE);
    send_line();
    build_line("a) b", "1844674407370955165", "1844674407370955166", "000042", 22,
               TERM_EOL_ONLY);
    send_line();
    build_line("cat", "3", "4", "5", 22, TERM_NEWLINE_JUNK);
    send_line();
    build_line("t", "\t9", "8", "7", 40, TERM_NUL_JUNK);
    send_line();
    build_line("z", "1", "2", "3", 14, TERM_NEWLINE);
    send_line();
    build_line("q\n", "1", "2", "3", 22, TERM_NEWLINE);
    send_line();
    push_text("1 (p)");
    send_line();

    while (bytes_sent < ITEM_TARGET || lines_sent < MIN_LINES) begin
      if (lines_sent == PRESSURE_AT) run_backpressure();
      quiet = ($urandom_range(0, 7) == 0);
      src_quiet = quiet;
      sink_quiet = quiet;
      if ($urandom_range(0, 99) < 80)
        build_line(comm_text(), key_field_text(), key_field_text(), key_field_text(),
                   pick_last_field(), line_end_t'($urandom_range(0, 3)));
      else
        build_noise();
      send_line();
    end
    in_ch.valid <= 1'b0;
    sink_quiet = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes in %0d lines; %0d line totals checked, %0d with cpu ticks,",
             bytes_sent, lines_sent, board.checked, board.cpu_seen);
    $display("%0d with a start time; %0d long result-side hold-offs.",
             board.start_seen, holds_done);
    if (board.errors == 0)
      $display("stat_line_field_extractor verification clean");
    else
      $display("stat_line_field_extractor verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/slfe_pkg.sv
rtl/slfe_if.sv
rtl/stat_line_field_extractor.sv
tb/stat_line_field_extractor_tb.sv
